// ----- hdl/bcah_pkg.sv -----
// ----------------------------------------------------------------------------
// Content address hash package
// Shared constants and small mixing functions for the block hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package bcah_pkg;

   localparam int DIGEST_BYTES = 20;
   localparam int LANE_IDX_W   = $clog2(DIGEST_BYTES);
   localparam int LANE_W       = 8;
   localparam int LANE_SHIFT   = 5;

   localparam int MUL_W        = 32;
   localparam int PROD_W       = 2 * MUL_W;

   localparam int ACC_W        = 64;
   localparam int FOLD_SHIFT   = 33;

   localparam int COUNT_W      = 32;
   localparam int DIV_STEPS    = ACC_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [LANE_W-1:0] LANE_MUL_A = 8'hCD;
   localparam logic [LANE_W-1:0] LANE_MUL_B = 8'h53;
   localparam logic [ACC_W-1:0]  FOLD_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [ACC_W-1:0]  FOLD_MUL_B = 64'hc4ceb9fe1a85ec53;

   function automatic logic [LANE_W-1:0] lane_xs(input logic [LANE_W-1:0] x);
      return x ^ (x >> LANE_SHIFT);
   endfunction

   function automatic logic [ACC_W-1:0] fold_xs(input logic [ACC_W-1:0] x);
      return x ^ (x >> FOLD_SHIFT);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/bcah_mul32.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 by 32 bit unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module bcah_mul32 (
   input  wire logic                        clock,
   input  wire logic [bcah_pkg::MUL_W-1:0]  op_a,
   input  wire logic [bcah_pkg::MUL_W-1:0]  op_b,
   output logic      [bcah_pkg::PROD_W-1:0] prod_ff
);
   import bcah_pkg::*;

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- hdl/bcah_mod.sv -----
// ----------------------------------------------------------------------------
// Iterative modulo unit
// Restoring division of a 64-bit value by a 32-bit divisor, one quotient bit
// per cycle, returning only the remainder. A zero divisor returns zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bcah_mod (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bcah_pkg::ACC_W-1:0]   dividend,
   input  wire logic [bcah_pkg::COUNT_W-1:0] divisor,
   output logic                              done_ff,
   output logic      [bcah_pkg::COUNT_W-1:0] remainder
);
   import bcah_pkg::*;

   logic                 busy_ff,  busy_in;
   logic                 done_in;
   logic [DIV_CNT_W-1:0] cnt_ff,   cnt_in;
   logic [ACC_W-1:0]     dvd_ff,   dvd_in;
   logic [COUNT_W-1:0]   rem_ff,   rem_in;
   logic [COUNT_W-1:0]   div_ff,   div_in;
   logic [COUNT_W:0]     trial;

   assign trial = {rem_ff, dvd_ff[ACC_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[COUNT_W-1:0];
         end
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign remainder = (div_ff == '0) ? '0 : rem_ff;

endmodule

`default_nettype wire

// ----- hdl/block_content_address_hash_core.sv -----
// ----------------------------------------------------------------------------
// Block content address hash core
// Mixes the bytes of one storage block into a 20-byte digest, folds the digest
// into a 64-bit hash at the end of the block and returns the hash modulo the
// configured block count as the block index.
// ----------------------------------------------------------------------------
// Each byte transfer runs the byte mix, whose two multiplies go through the
// single shared 32 by 32 multiplier, whose product is registered; no new
// byte is taken until the mixed lane is written. A byte flagged as last adds
// the digest fold and the modulo: the fold works through each of the 20
// digest lanes (every 64-bit multiply is three partial products on the same
// multiplier), then the bit-serial modulo unit runs and the result is shown.
// The next byte is taken while an earlier result still waits on the response
// channel, but the end of a block stalls until its result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module block_content_address_hash_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] block_index
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import bcah_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MIX_A   = 4'd1;
   localparam logic [3:0] S_MIX_B   = 4'd2;
   localparam logic [3:0] S_MIX_W   = 4'd3;
   localparam logic [3:0] S_FOLD_LD = 4'd4;
   localparam logic [3:0] S_FOLD_MU = 4'd5;
   localparam logic [3:0] S_MOD_GO  = 4'd6;
   localparam logic [3:0] S_MOD_RUN = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   logic [3:0]              state_ff,    state_in;
   logic [LANE_IDX_W-1:0]   pos_ff,      pos_in;
   logic [LANE_IDX_W-1:0]   fold_idx_ff, fold_idx_in;
   logic                    last_ff,     last_in;
   logic [LANE_W-1:0]       mix_ff,      mix_in;
   logic [1:0]              sub_ff,      sub_in;
   logic                    csel_ff,     csel_in;
   logic [ACC_W-1:0]        acc_ff,      acc_in;
   logic [ACC_W-1:0]        sum_ff,      sum_in;
   logic [COUNT_W-1:0]      res_ff,      res_in;
   logic                    rsp_vld_ff,  rsp_vld_in;
   logic [COUNT_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]      blk_cnt_ff,  blk_cnt_in;
   logic [DIGEST_BYTES-1:0] lane_vld_ff, lane_vld_in;
   logic [LANE_W-1:0]       lanes_ff [DIGEST_BYTES];

   logic                    req_xfer;
   logic                    rsp_load;
   logic                    lane_we;
   logic [LANE_W-1:0]       lane_wdata;
   logic [LANE_IDX_W-1:0]   lane_rd_idx;
   logic [LANE_W-1:0]       lane_rd;
   logic [ACC_W-1:0]        fold_k;
   logic [ACC_W-1:0]        prod_sum;
   logic [MUL_W-1:0]        mul_a;
   logic [MUL_W-1:0]        mul_b;
   logic [PROD_W-1:0]       mul_p;
   logic                    mod_start;
   logic                    mod_done;
   logic [COUNT_W-1:0]      mod_rem;

   bcah_mul32 u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   bcah_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (acc_ff),
      .divisor   (blk_cnt_ff),
      .done_ff   (mod_done),
      .remainder (mod_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign mod_start  = (state_ff == S_MOD_GO);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_vld_ff || rsp_tready);

   assign lane_rd_idx = (state_ff == S_FOLD_LD) ? fold_idx_ff : pos_ff;
   assign lane_rd     = lane_vld_ff[lane_rd_idx] ? lanes_ff[lane_rd_idx] : '0;
   assign fold_k      = csel_ff ? FOLD_MUL_B : FOLD_MUL_A;
   assign prod_sum    = {sum_ff[ACC_W-1:MUL_W] + mul_p[MUL_W-1:0], sum_ff[MUL_W-1:0]};
   assign lane_we     = (state_ff == S_MIX_W);
   assign lane_wdata  = lane_xs(mul_p[LANE_W-1:0]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MIX_A: begin
            mul_a = MUL_W'(mix_ff);
            mul_b = MUL_W'(LANE_MUL_A);
         end
         S_MIX_B: begin
            mul_a = MUL_W'(lane_xs(mul_p[LANE_W-1:0]));
            mul_b = MUL_W'(LANE_MUL_B);
         end
         S_FOLD_MU: begin
            case (sub_ff)
               2'd0: begin
                  mul_a = acc_ff[MUL_W-1:0];
                  mul_b = fold_k[MUL_W-1:0];
               end
               2'd1: begin
                  mul_a = acc_ff[MUL_W-1:0];
                  mul_b = fold_k[ACC_W-1:MUL_W];
               end
               2'd2: begin
                  mul_a = acc_ff[ACC_W-1:MUL_W];
                  mul_b = fold_k[MUL_W-1:0];
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      fold_idx_in = fold_idx_ff;
      last_in     = last_ff;
      mix_in      = mix_ff;
      sub_in      = sub_ff;
      csel_in     = csel_ff;
      acc_in      = acc_ff;
      sum_in      = sum_ff;
      res_in      = res_ff;
      lane_vld_in = lane_vld_ff;
      blk_cnt_in  = csr_valid ? csr_data : blk_cnt_ff;
      rsp_vld_in  = rsp_tready ? 1'b0 : rsp_vld_ff;
      rsp_data_in = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mix_in   = lane_xs(lane_rd ^ req_tdata);
               last_in  = req_tlast;
               state_in = S_MIX_A;
            end
         end
         S_MIX_A: begin
            state_in = S_MIX_B;
         end
         S_MIX_B: begin
            state_in = S_MIX_W;
         end
         S_MIX_W: begin
            lane_vld_in[pos_ff] = 1'b1;
            pos_in = (pos_ff == LANE_IDX_W'(DIGEST_BYTES - 1)) ? '0 : pos_ff + 1'b1;
            if (last_ff) begin
               fold_idx_in = '0;
               acc_in      = '0;
               state_in    = S_FOLD_LD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FOLD_LD: begin
            acc_in   = fold_xs(acc_ff ^ ACC_W'(lane_rd));
            sub_in   = '0;
            csel_in  = 1'b0;
            state_in = S_FOLD_MU;
         end
         S_FOLD_MU: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               2'd1: begin
                  sum_in = mul_p;
               end
               2'd2: begin
                  sum_in = prod_sum;
               end
               2'd3: begin
                  acc_in = fold_xs(prod_sum);
                  if (!csel_ff) begin
                     csel_in = 1'b1;
                  end else if (fold_idx_ff == LANE_IDX_W'(DIGEST_BYTES - 1)) begin
                     state_in = S_MOD_GO;
                  end else begin
                     fold_idx_in = fold_idx_ff + 1'b1;
                     state_in    = S_FOLD_LD;
                  end
               end
               default: begin
                  sum_in = sum_ff;
               end
            endcase
         end
         S_MOD_GO: begin
            state_in = S_MOD_RUN;
         end
         S_MOD_RUN: begin
            if (mod_done) begin
               res_in   = mod_rem;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               lane_vld_in = '0;
               pos_in      = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pos_ff      <= '0;
         fold_idx_ff <= '0;
         last_ff     <= 1'b0;
         sub_ff      <= '0;
         csel_ff     <= 1'b0;
         acc_ff      <= '0;
         lane_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         blk_cnt_ff  <= COUNT_W'(1);
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         fold_idx_ff <= fold_idx_in;
         last_ff     <= last_in;
         sub_ff      <= sub_in;
         csel_ff     <= csel_in;
         acc_ff      <= acc_in;
         lane_vld_ff <= lane_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         blk_cnt_ff  <= blk_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff      <= mix_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (lane_we) begin
         lanes_ff[pos_ff] <= lane_wdata;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/block_content_address_hash_checker.sv -----
// ----------------------------------------------------------------------------
// Block content address hash checker
// Port-level assertions on the hash core, attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module block_content_address_hash_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // A stalled result keeps its value until the transfer completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every accepted byte keeps the mixer busy, so the input is not ready after it.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("byte accepted while mixer busy");

   // A byte that does not end a block never produces a result.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result without a last byte");

   // The end of a block keeps the input stalled through the fold.
   a_fold_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> ##8 !req_tready)
      else $error("input reopened during the fold");

endmodule

bind block_content_address_hash_core block_content_address_hash_checker u_checker (.*);

`default_nettype wire

// ----- bench/block_content_address_hash_core_tb.sv -----
// ----------------------------------------------------------------------------
// Block content address hash core testbench
// Streams directed, then random-length storage blocks one byte per transfer,
// rewrites the block count between blocks, and checks every returned block
// index against a set value or a model of byte mix, digest fold and modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module block_content_address_hash_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import bcah_pkg::*;

   localparam int          RANDOM_ITEMS  = 1100;
   localparam int          SETTLE_CYCLES = 300;
   localparam int          STALL_LIMIT   = 20000;
   localparam logic [7:0]  MIX_MUL_A     = 8'hCD;
   localparam logic [7:0]  MIX_MUL_B     = 8'h53;
   localparam logic [63:0] HASH_MUL_A    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] HASH_MUL_B    = 64'hc4ceb9fe1a85ec53;

   typedef struct packed {
      bit          set_count;
      logic [31:0] count;
      logic [7:0]  data;
      int          run;
      bit          last;
      bit          known;
      logic [31:0] index;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] block_index
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   logic [7:0]  digest [DIGEST_BYTES];
   int          lane_pos    = 0;
   logic [31:0] modulus     = 32'd1;
   logic [31:0] index_queue [$];

   int fail_count  = 0;
   int idle_cycles = 0;
   int rx_hold     = 0;
   int rx_quiet    = 0;
   bit tx_burst    = 1'b0;

   // Single-byte blocks first at the reset count, then a two-byte block at the
   // zero count, then a block that wraps past the last digest lane.
   vector_type directed_rows [0:8] = '{
      '{1'b0, 32'h0000_0000, 8'h00,  1, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 8'hFF,  1, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b1, 32'h0000_0000, 8'hA5,  1, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 8'h5A,  1, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b1, 32'hFFFF_FFFF, 8'h00,  1, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 8'hFF,  1, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 8'h3C, 20, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b1, 32'h0000_0007, 8'h81,  2, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b1, 32'h8000_0000, 8'h7E,  1, 1'b1, 1'b0, 32'h0000_0000}
   };

   block_content_address_hash_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] scramble_lane(input logic [7:0] lane, input logic [7:0] b);
      logic [7:0] x;
      x = lane ^ b;
      x = x ^ (x >> 5);
      x = x * MIX_MUL_A;
      x = x ^ (x >> 5);
      x = x * MIX_MUL_B;
      x = x ^ (x >> 5);
      return x;
   endfunction

   function automatic logic [31:0] digest_to_index();
      logic [63:0] acc;
      acc = 64'd0;
      for (int i = 0; i < DIGEST_BYTES; i++) begin
         acc = acc ^ {56'd0, digest[i]};
         acc = acc ^ (acc >> 33);
         acc = acc * HASH_MUL_A;
         acc = acc ^ (acc >> 33);
         acc = acc * HASH_MUL_B;
         acc = acc ^ (acc >> 33);
      end
      if (modulus == 32'd0) begin
         return 32'd0;
      end
      return 32'(acc % {32'd0, modulus});
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_burst || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(40, 300);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 1;
      end else if (r < 70) begin
         return $urandom_range(2, 24);
      end else if (r < 95) begin
         return $urandom_range(25, 64);
      end
      return $urandom_range(65, 300);
   endfunction

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'($urandom_range(2, 16));
         4:       return 32'h8000_0000;
         5:       return 32'($urandom());
         6:       return 32'($urandom_range(1, 1000));
         default: return 32'hFFFF_FFFE;
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b, input bit last, input bit known,
                            input logic [31:0] index);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      digest[lane_pos] = scramble_lane(digest[lane_pos], b);
      lane_pos = (lane_pos + 1) % DIGEST_BYTES;
      if (last) begin
         index_queue.push_back(known ? index : digest_to_index());
         for (int i = 0; i < DIGEST_BYTES; i++) begin
            digest[i] = 8'h00;
         end
         lane_pos = 0;
      end
   endtask

   task automatic write_modulus(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (index_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      modulus    = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold != 0) begin
         rx_hold    <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rx_quiet != 0) begin
         rx_quiet   <= rx_quiet - 1;
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         case ($urandom_range(0, 19))
            0:             rx_quiet <= $urandom_range(100, 600);
            1:             rx_hold  <= $urandom_range(30, 200);
            2, 3, 4, 5, 6: rx_hold  <= $urandom_range(1, 4);
            default:       ;
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      logic [31:0] want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (index_queue.size() == 0) begin
               $error("block_index: unexpected transfer, actual %0d", rsp_tdata);
               fail_count++;
            end else begin
               want = index_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $error("block_index mismatch: expected %0d, actual %0d", want, rsp_tdata);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int len;
      for (int i = 0; i < DIGEST_BYTES; i++) begin
         digest[i] = 8'h00;
      end
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_count) begin
            write_modulus(directed_rows[r].count);
         end
         for (int k = 0; k < directed_rows[r].run; k++) begin
            push_byte(directed_rows[r].data,
                      directed_rows[r].last && (k == directed_rows[r].run - 1),
                      directed_rows[r].known, directed_rows[r].index);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            write_modulus(pick_count());
         end
         tx_burst = ($urandom_range(0, 3) == 0);
         len = pick_length();
         if (len > RANDOM_ITEMS - sent) begin
            len = RANDOM_ITEMS - sent;
         end
         for (int k = 0; k < len; k++) begin
            push_byte(pick_data(), k == len - 1, 1'b0, 32'd0);
         end
         sent += len;
      end

      req_tvalid <= 1'b0;
      while (index_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
